// ----- sv/plsr_pkg.sv -----
// Shared constants, codes and state types of the plane side and ray intersect unit.
package plsr_pkg;

    // Fixed-point format of all words
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Digit-serial multiplier: multiplier operand enters one digit per cycle
    localparam int DIGIT_BITS = 4;
    localparam int NUM_DIGITS = WORD_BITS / DIGIT_BITS;

    // Exact widths of products, dot sums and the divider dividend
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int DOT_W     = 2 * WORD_BITS + 2;
    localparam int NUM_W     = DOT_W + FRAC_BITS;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int HSUM_W    = PROD_W - FRAC_BITS + 1;
    localparam int SDIST_W   = DOT_W - FRAC_BITS;

    // Packed stream widths
    localparam int IN_FIELDS_W  = 6 * WORD_BITS + (WORD_BITS - 1) + 2;
    localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 + 5 * WORD_BITS;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_EPSILON  = 3'd4;

    // Reset values of the plane registers
    localparam logic [WORD_BITS-1:0] NORMAL_Z_RESET = WORD_BITS'(1) << FRAC_BITS;
    localparam logic [WORD_BITS-2:0] EPSILON_RESET  = (WORD_BITS-1)'(66);

    // Opcodes
    localparam logic [2:0] OP_POINT_EPS = 3'd0;
    localparam logic [2:0] OP_POINT_THR = 3'd1;
    localparam logic [2:0] OP_SPHERE    = 3'd2;
    localparam logic [2:0] OP_SET       = 3'd3;
    localparam logic [2:0] OP_ISECT     = 3'd4;

    // Side classes
    localparam logic [1:0] SIDE_FRONT    = 2'd0;
    localparam logic [1:0] SIDE_BACK     = 2'd1;
    localparam logic [1:0] SIDE_COPLANAR = 2'd2;
    localparam logic [1:0] SIDE_STRADDLE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_ACC,
        S_CLASS,
        S_DECIDE,
        S_DIV,
        S_TSAT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_DIST,
        PH_DEN,
        PH_HIT
    } phase_t;

endpackage

// ----- sv/plane_side_and_ray_intersect.sv -----
// Plane query unit: point, sphere and point-set classification and line/ray crossing.
//
// Usage: the user must write the plane (normal, offset, epsilon) via cfg_ only while
// the unit is idle (not enforced). Each write is a cfg_valid/cfg_ready transfer.
// Queries arrive on the s_ stream: opcode in s_tuser, last point of a set on s_tlast,
// everything else in s_tdata. One query is worked on at a time.
// Each query produces at most one result on the m_ stream. Opcodes above four and
// point-set members without tlast produce nothing.
// Work per query: the signed distance takes three products through a radix-16
// serial multiplier, each product a load, the digit steps and an accumulate step;
// classification follows. Intersection then forms n.dir the same way, takes a
// decision step, runs a restoring divider (one quotient bit per cycle), saturates t
// and forms the hit point with three more products. A parallel or rejected query
// skips the divider and the hit point.
// The result waits in an output register. A new query is taken as soon as the
// unit is idle, even while that result is still waiting. A stalled receiver holds
// back only the next result.
// Reset (aresetn low, synchronous) restores the default plane (normal +z, offset 0,
// epsilon 66), clears the point-set flags and drops any pending result.
module plane_side_and_ray_intersect
    import plsr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [WORD_BITS-1:0]   cfg_data,
    // query stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, radius_or_limit, two_sided, ray_mode
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [2:0]             s_tuser,
    input  logic                   s_tlast,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // side_class, hit, t_param, hit_x, hit_y, hit_z, signed_distance
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int W = WORD_BITS;

    // Plane registers
    logic signed [W-1:0] normal_reg [3];
    logic signed [W-1:0] offset_reg;
    logic [W-2:0]        epsilon_reg;

    // Query registers
    logic [2:0]          opcode_reg;
    logic signed [W-1:0] pos_reg [3];
    logic signed [W-1:0] dir_reg [3];
    logic [W-2:0]        limit_reg;
    logic                two_sided_reg, ray_mode_reg, last_reg;

    // Control
    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [1:0]       idx_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Serial multiplier
    logic signed [W-1:0]      mul_a_reg;
    logic [W-1:0]             mul_b_reg;
    logic signed [PROD_W-1:0] acc_reg;

    // Dot sums
    logic signed [DOT_W-1:0] dot_reg, dist_reg, den_reg;

    // Divider
    logic [DOT_W-1:0] rem_reg, divisor_reg;
    logic [NUM_W-1:0] quo_reg;
    logic             qneg_reg;

    // Result fields
    logic [1:0]          side_reg;
    logic                hit_reg;
    logic signed [W-1:0] t_reg;
    logic signed [W-1:0] hpt_reg [3];
    logic                front_reg, back_reg;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic s_accept, m_accept, load_out, last_idx;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_valid_reg && m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign last_idx  = (idx_reg == 2'd2);

    // Multiplier step: top digit of the shifting operand, signed on the first digit
    logic [DIGIT_BITS-1:0]           digit;
    logic signed [DIGIT_BITS:0]      digit_s;
    logic signed [W+DIGIT_BITS:0]    part;
    logic signed [PROD_W-1:0]        acc_step;
    assign digit    = mul_b_reg[W-1 -: DIGIT_BITS];
    assign digit_s  = $signed({(cnt_reg == '0) ? digit[DIGIT_BITS-1] : 1'b0, digit});
    assign part     = mul_a_reg * digit_s;
    assign acc_step = (acc_reg <<< DIGIT_BITS) + PROD_W'(part);

    // Dot accumulation and hit coordinate
    logic signed [DOT_W-1:0]  dot_sum;
    logic signed [HSUM_W-1:0] hsum;
    logic signed [W-1:0]      hsat;
    assign dot_sum = dot_reg + DOT_W'(acc_reg);
    assign hsum    = HSUM_W'(pos_reg[idx_reg]) + HSUM_W'(acc_reg >>> FRAC_BITS);
    always_comb begin
        if (hsum[HSUM_W-1:W-1] == '0 || hsum[HSUM_W-1:W-1] == '1) begin
            hsat = hsum[W-1:0];
        end else if (hsum[HSUM_W-1]) begin
            hsat = {1'b1, {(W-1){1'b0}}};
        end else begin
            hsat = {1'b0, {(W-1){1'b1}}};
        end
    end

    // Thresholds scaled to the product format
    logic signed [DOT_W-1:0] eps2, lim2, thr2, neg_dist;
    assign eps2     = DOT_W'({epsilon_reg, {FRAC_BITS{1'b0}}});
    assign lim2     = DOT_W'({limit_reg, {FRAC_BITS{1'b0}}});
    assign thr2     = (opcode_reg == OP_POINT_THR) ? lim2 : eps2;
    assign neg_dist = -dist_reg;

    // Classification of the finished distance
    logic [1:0] cls, side_c;
    logic       front_c, back_c;
    always_comb begin
        if (dist_reg > thr2) begin
            cls = SIDE_FRONT;
        end else if (dist_reg < -thr2) begin
            cls = SIDE_BACK;
        end else begin
            cls = SIDE_COPLANAR;
        end
        front_c = front_reg || (cls == SIDE_FRONT);
        back_c  = back_reg || (cls == SIDE_BACK);
        case (opcode_reg)
            OP_SPHERE: begin
                if (!dist_reg[DOT_W-1]) begin
                    side_c = (dist_reg > lim2) ? SIDE_FRONT : SIDE_STRADDLE;
                end else begin
                    side_c = (neg_dist > lim2) ? SIDE_BACK : SIDE_STRADDLE;
                end
            end
            OP_SET: begin
                if (front_c && back_c) begin
                    side_c = SIDE_STRADDLE;
                end else if (front_c) begin
                    side_c = SIDE_FRONT;
                end else if (back_c) begin
                    side_c = SIDE_BACK;
                end else begin
                    side_c = SIDE_COPLANAR;
                end
            end
            default: side_c = cls;
        endcase
    end

    // Crossing decision
    logic isect_ok;
    logic [DOT_W-1:0] num_mag, den_mag;
    always_comb begin
        isect_ok = (den_reg <= -eps2) || (two_sided_reg && den_reg >= eps2);
        if (den_reg == '0) begin
            isect_ok = 1'b0;
        end
        // ray: t negative when numerator (-dist) and den differ in sign
        if (ray_mode_reg && dist_reg != '0
            && ((dist_reg > 0) != den_reg[DOT_W-1])) begin
            isect_ok = 1'b0;
        end
        num_mag = dist_reg[DOT_W-1] ? neg_dist : dist_reg;
        den_mag = den_reg[DOT_W-1] ? -den_reg : den_reg;
    end

    // Divider step
    logic [DOT_W:0] div_r, div_d;
    logic           div_ge;
    assign div_r  = {rem_reg, quo_reg[NUM_W-1]};
    assign div_d  = div_r - {1'b0, divisor_reg};
    assign div_ge = !div_d[DOT_W];

    // Saturation of t
    logic signed [W-1:0] t_sat;
    always_comb begin
        if (qneg_reg) begin
            if (|quo_reg[NUM_W-1:W] || (quo_reg[W-1] && |quo_reg[W-2:0])) begin
                t_sat = {1'b1, {(W-1){1'b0}}};
            end else begin
                t_sat = -quo_reg[W-1:0];
            end
        end else if (|quo_reg[NUM_W-1:W-1]) begin
            t_sat = {1'b0, {(W-1){1'b1}}};
        end else begin
            t_sat = quo_reg[W-1:0];
        end
    end

    // Saturated signed distance
    logic signed [SDIST_W-1:0] sd_wide;
    logic signed [W-1:0]       sd_sat;
    assign sd_wide = SDIST_W'(dist_reg >>> FRAC_BITS);
    always_comb begin
        if (sd_wide[SDIST_W-1:W-1] == '0 || sd_wide[SDIST_W-1:W-1] == '1) begin
            sd_sat = sd_wide[W-1:0];
        end else if (sd_wide[SDIST_W-1]) begin
            sd_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            sd_sat = {1'b0, {(W-1){1'b1}}};
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && s_tuser <= OP_ISECT) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: state_next = S_MUL;
            S_MUL: begin
                if (cnt_reg == CNT_W'(NUM_DIGITS - 1)) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                if (!last_idx) begin
                    state_next = S_LOAD;
                end else begin
                    case (phase_reg)
                        PH_DIST: state_next = (opcode_reg == OP_ISECT) ? S_LOAD : S_CLASS;
                        PH_DEN:  state_next = S_DECIDE;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_CLASS: begin
                state_next = (opcode_reg == OP_SET && !last_reg) ? S_IDLE : S_DONE;
            end
            S_DECIDE: state_next = isect_ok ? S_DIV : S_DONE;
            S_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_TSAT;
                end
            end
            S_TSAT: state_next = S_LOAD;
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        load_out = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            front_reg     <= 1'b0;
            back_reg      <= 1'b0;
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= NORMAL_Z_RESET;
            offset_reg    <= '0;
            epsilon_reg   <= EPSILON_RESET;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_accept) begin
                m_valid_reg <= 1'b0;
            end
            // point-set flags
            if (state_reg == S_CLASS && opcode_reg == OP_SET) begin
                front_reg <= last_reg ? 1'b0 : front_c;
                back_reg  <= last_reg ? 1'b0 : back_c;
            end
            // configuration transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NORMAL_X: normal_reg[0] <= cfg_data;
                    REG_NORMAL_Y: normal_reg[1] <= cfg_data;
                    REG_NORMAL_Z: normal_reg[2] <= cfg_data;
                    REG_OFFSET:   offset_reg    <= cfg_data;
                    REG_EPSILON:  epsilon_reg   <= cfg_data[W-2:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    opcode_reg    <= s_tuser;
                    last_reg      <= s_tlast;
                    pos_reg[0]    <= s_tdata[0*W +: W];
                    pos_reg[1]    <= s_tdata[1*W +: W];
                    pos_reg[2]    <= s_tdata[2*W +: W];
                    dir_reg[0]    <= s_tdata[3*W +: W];
                    dir_reg[1]    <= s_tdata[4*W +: W];
                    dir_reg[2]    <= s_tdata[5*W +: W];
                    limit_reg     <= s_tdata[6*W +: W-1];
                    two_sided_reg <= s_tdata[7*W-1];
                    ray_mode_reg  <= s_tdata[7*W];
                    phase_reg     <= PH_DIST;
                    idx_reg       <= '0;
                    dot_reg       <= -(DOT_W'(offset_reg) <<< FRAC_BITS);
                    side_reg      <= SIDE_FRONT;
                    hit_reg       <= 1'b0;
                    t_reg         <= '0;
                    hpt_reg[0]    <= '0;
                    hpt_reg[1]    <= '0;
                    hpt_reg[2]    <= '0;
                end
            end
            S_LOAD: begin
                mul_a_reg <= (phase_reg == PH_HIT) ? t_reg : normal_reg[idx_reg];
                mul_b_reg <= (phase_reg == PH_DIST) ? pos_reg[idx_reg] : dir_reg[idx_reg];
                acc_reg   <= '0;
                cnt_reg   <= '0;
            end
            S_MUL: begin
                acc_reg   <= acc_step;
                mul_b_reg <= mul_b_reg << DIGIT_BITS;
                cnt_reg   <= cnt_reg + 1'b1;
            end
            S_ACC: begin
                idx_reg <= last_idx ? 2'd0 : idx_reg + 1'b1;
                if (phase_reg == PH_HIT) begin
                    hpt_reg[idx_reg] <= hsat;
                end else begin
                    dot_reg <= last_idx ? '0 : dot_sum;
                end
                if (last_idx && phase_reg == PH_DIST) begin
                    dist_reg  <= dot_sum;
                    phase_reg <= PH_DEN;
                end
                if (last_idx && phase_reg == PH_DEN) begin
                    den_reg <= dot_sum;
                end
            end
            S_CLASS: begin
                side_reg <= side_c;
            end
            S_DECIDE: begin
                rem_reg     <= '0;
                divisor_reg <= den_mag;
                quo_reg     <= {num_mag, {FRAC_BITS{1'b0}}};
                qneg_reg    <= (dist_reg > 0) != den_reg[DOT_W-1];
                cnt_reg     <= '0;
            end
            S_DIV: begin
                rem_reg <= div_ge ? div_d[DOT_W-1:0] : div_r[DOT_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], div_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_TSAT: begin
                t_reg     <= t_sat;
                hit_reg   <= 1'b1;
                phase_reg <= PH_HIT;
                idx_reg   <= '0;
            end
            default: ;
        endcase
        if (load_out) begin
            m_data_reg <= M_TDATA_W'({sd_sat, hpt_reg[2], hpt_reg[1], hpt_reg[0],
                                      t_reg, hit_reg, side_reg});
        end
    end

    // Checks
    a_drop_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser > OP_ISECT) |=> state_reg == S_IDLE)
        else $error("unknown opcode started work");

    a_hit_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> m_tdata[1:0] == SIDE_FRONT)
        else $error("hit result with nonzero side class");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> cnt_reg < CNT_W'(DIV_STEPS))
        else $error("divider ran past its step count");

    a_set_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLASS && opcode_reg == OP_SET && last_reg)
        |=> (!front_reg && !back_reg))
        else $error("point-set flags not cleared after last point");

    a_mul_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |-> cnt_reg < CNT_W'(NUM_DIGITS))
        else $error("multiplier ran past its digit count");

endmodule
